// ===== rtl/color_command_parser_core_macros.svh =====
// Assertion macros shared by the color command parser RTL.
`ifndef COLOR_COMMAND_PARSER_CORE_MACROS_SVH
`define COLOR_COMMAND_PARSER_CORE_MACROS_SVH

// Same-cycle implication, checked on the clock edge outside reset.
`define CCP_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("color command parser: same-cycle check failed");

// Next-cycle implication, checked on the clock edge outside reset.
`define CCP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("color command parser: next-cycle check failed");

`endif

// ===== rtl/ccp_pkg.sv =====
// Types, character codes and helper functions for the color command parser.
`default_nettype none

package ccp_pkg;

   localparam logic [7:0] CHAR_HASH    = 8'h23;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_B = 8'h42;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;
   localparam logic [7:0] CHAR_UPPER_G = 8'h47;
   localparam logic [7:0] CHAR_UPPER_O = 8'h4F;
   localparam logic [7:0] CHAR_UPPER_R = 8'h52;
   localparam logic [7:0] CHAR_UPPER_W = 8'h57;
   localparam logic [7:0] CHAR_UPPER_Y = 8'h59;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_B = 8'h62;
   localparam logic [7:0] CHAR_LOWER_F = 8'h66;
   localparam logic [7:0] CHAR_LOWER_G = 8'h67;
   localparam logic [7:0] CHAR_LOWER_O = 8'h6F;
   localparam logic [7:0] CHAR_LOWER_R = 8'h72;
   localparam logic [7:0] CHAR_LOWER_W = 8'h77;
   localparam logic [7:0] CHAR_LOWER_Y = 8'h79;

   localparam logic [7:0] LEVEL_MAX    = 8'd255;
   localparam logic [7:0] DIGIT_TEN    = 8'd10;
   localparam logic [2:0] POS_LAST_HEX = 3'd6;
   localparam logic [2:0] POS_MAX      = 3'd7;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       matched;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  red_level;
      logic [7:0]  green_level;
      logic [7:0]  blue_level;
      logic [7:0]  lead_char;
      logic [2:0]  char_position;
      logic [7:0]  decimal_accum;
      logic [23:0] hex_word;
   } state_type;

   function automatic logic is_decimal(input logic [7:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

   // Non-hex characters count as a zero digit.
   function automatic logic [3:0] hex_digit_value(input logic [7:0] c);
      logic [7:0] t;
      t = 8'd0;
      if (is_decimal(c)) begin
         t = c - CHAR_ZERO;
      end else if ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_F)) begin
         t = c - CHAR_UPPER_A + DIGIT_TEN;
      end else if ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_F)) begin
         t = c - CHAR_LOWER_A + DIGIT_TEN;
      end
      return t[3:0];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/ccp_step.sv =====
// Per-character state update and result formation for the color command parser.
`default_nettype none

module ccp_step (
   input  ccp_pkg::state_type state_cur,
   input  ccp_pkg::req_type   req_cur,
   output ccp_pkg::state_type state_nxt,
   output ccp_pkg::rsp_type   rsp_nxt
);
   import ccp_pkg::*;

   state_type  upd;
   logic [2:0] pos;
   logic [7:0] c;
   logic [7:0] dig_off;
   logic [11:0] dec_sum;
   logic [4:0] hex_shift;
   logic [7:0] v;
   logic       matched;

   assign pos       = state_cur.char_position;
   assign c         = req_cur.char_code;
   assign dig_off   = c - CHAR_ZERO;
   assign dec_sum   = {1'b0, state_cur.decimal_accum, 3'b000}
                    + {3'b000, state_cur.decimal_accum, 1'b0}
                    + {8'd0, dig_off[3:0]};
   assign hex_shift = {POS_LAST_HEX - pos, 2'b00};

   always_comb begin
      upd = state_cur;
      if (pos == 3'd0) begin
         upd.lead_char = c;
      end else if (state_cur.lead_char == CHAR_HASH) begin
         if (pos <= POS_LAST_HEX) begin
            upd.hex_word = state_cur.hex_word
                         | ({20'd0, hex_digit_value(c)} << hex_shift);
         end
      end else if (is_decimal(c)) begin
         upd.decimal_accum = (dec_sum > {4'd0, LEVEL_MAX}) ? LEVEL_MAX : dec_sum[7:0];
      end
      if (pos < POS_MAX) begin
         upd.char_position = pos + 3'd1;
      end
   end

   assign v = upd.decimal_accum;

   always_comb begin
      state_nxt = upd;
      matched   = 1'b1;
      if (upd.lead_char == CHAR_HASH) begin
         state_nxt.red_level   = upd.hex_word[23:16];
         state_nxt.green_level = upd.hex_word[15:8];
         state_nxt.blue_level  = upd.hex_word[7:0];
      end else begin
         unique case (upd.lead_char) inside
            CHAR_UPPER_R, CHAR_LOWER_R: begin
               {state_nxt.red_level, state_nxt.green_level, state_nxt.blue_level} =
                  {v, 8'd0, 8'd0};
            end
            CHAR_UPPER_G, CHAR_LOWER_G: begin
               {state_nxt.red_level, state_nxt.green_level, state_nxt.blue_level} =
                  {8'd0, v, 8'd0};
            end
            CHAR_UPPER_B, CHAR_LOWER_B: begin
               {state_nxt.red_level, state_nxt.green_level, state_nxt.blue_level} =
                  {8'd0, 8'd0, v};
            end
            CHAR_UPPER_Y, CHAR_LOWER_Y: begin
               {state_nxt.red_level, state_nxt.green_level, state_nxt.blue_level} =
                  {v, v, 8'd0};
            end
            CHAR_UPPER_A, CHAR_LOWER_A: begin
               {state_nxt.red_level, state_nxt.green_level, state_nxt.blue_level} =
                  {8'd0, v, v};
            end
            CHAR_UPPER_F, CHAR_LOWER_F: begin
               {state_nxt.red_level, state_nxt.green_level, state_nxt.blue_level} =
                  {v, 8'd0, v};
            end
            CHAR_UPPER_W, CHAR_LOWER_W: begin
               {state_nxt.red_level, state_nxt.green_level, state_nxt.blue_level} =
                  {v, v, v};
            end
            CHAR_UPPER_O, CHAR_LOWER_O: begin
               {state_nxt.red_level, state_nxt.green_level, state_nxt.blue_level} =
                  {8'd0, 8'd0, 8'd0};
            end
            default: begin
               matched = 1'b0;
            end
         endcase
      end
      if (req_cur.last) begin
         // The command is over, so the parse context starts fresh.
         state_nxt.char_position = 3'd0;
         state_nxt.decimal_accum = 8'd0;
         state_nxt.hex_word      = 24'd0;
      end else begin
         state_nxt.red_level   = state_cur.red_level;
         state_nxt.green_level = state_cur.green_level;
         state_nxt.blue_level  = state_cur.blue_level;
      end
   end

   assign rsp_nxt.red     = state_nxt.red_level;
   assign rsp_nxt.green   = state_nxt.green_level;
   assign rsp_nxt.blue    = state_nxt.blue_level;
   assign rsp_nxt.matched = matched;

endmodule

`default_nettype wire

// ===== rtl/color_command_parser_core.sv =====
// Color command parser top level: input register, character step logic, result register.
// A character marked last goes through the input register, then the result register.
// Throughput: one character per cycle unless stalled; the single state update sets this.
// A stalled result holds only a character marked last; other characters keep flowing.
// Synchronous active-high reset clears the levels, the parse context and both valid flags.
`default_nettype none
`include "color_command_parser_core_macros.svh"

module color_command_parser_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ccp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ccp_pkg::rsp_type rsp_data
);
   import ccp_pkg::*;

   logic      s1_valid_ff, s1_valid_in;
   req_type   s1_req_ff;
   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   rsp_type   rsp_data_ff;
   rsp_type   rsp_calc;
   logic      out_free;
   logic      s1_adv;
   logic      req_take;

   ccp_step u_step (
      .state_cur (state_ff),
      .req_cur   (s1_req_ff),
      .state_nxt (state_in),
      .rsp_nxt   (rsp_calc)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;
   // Only a last character needs room in the result register to move on.
   assign s1_adv   = s1_valid_ff && (!s1_req_ff.last || out_free);
   assign req_stall = s1_valid_ff && !s1_adv;
   assign req_take  = req_valid && !req_stall;

   assign s1_valid_in  = req_take || (s1_valid_ff && !s1_adv);
   assign rsp_valid_in = (s1_adv && s1_req_ff.last) || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_adv) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_req_ff <= req_data;
      end
      if (s1_adv && s1_req_ff.last) begin
         rsp_data_ff <= rsp_calc;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `CCP_ASSERT_NEXT(a_last_loads_rsp, s1_adv && s1_req_ff.last, rsp_valid_ff)
   `CCP_ASSERT_NEXT(a_last_clears_pos, s1_adv && s1_req_ff.last, state_ff.char_position == 3'd0)
   `CCP_ASSERT_IMP(a_free_out_no_stall, !rsp_valid_ff, !req_stall)
   `CCP_ASSERT_IMP(a_stall_needs_item, req_stall, s1_valid_ff && s1_req_ff.last)

endmodule

`default_nettype wire
